/* rtl/hom4_pkg.sv */
package hom4_pkg;

  localparam int COORD_BITS  = 13;
  localparam int FRAC_BITS   = 32;
  localparam int NROWS       = 8;
  localparam int NCOLS       = 9;
  localparam int MAT_DEPTH   = NROWS * NCOLS;
  localparam int ADDR_W      = 7;
  localparam int IDX_W       = 4;
  localparam int IN_TDATA_W  = ((4 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_W = IDX_W + 64;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  typedef logic signed [63:0] word_t;
  typedef logic signed [COORD_BITS-1:0] coord_t;

  localparam word_t WORD_MAX = {1'b0, {63{1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {63{1'b0}}};
  localparam word_t FIX_ONE  = 64'sd1 <<< FRAC_BITS;

  typedef enum logic [5:0] {
    ST_IDLE, ST_BUILD,
    ST_PS_START, ST_PS_ISS, ST_PS_CMP, ST_PS_DONE,
    ST_SW_RA, ST_SW_RB, ST_SW_W1, ST_SW_W2,
    ST_NM_PI, ST_NM_PW, ST_NM_ISS, ST_NM_LD, ST_DIV_RUN, ST_DIV_FIN, ST_NM_WR,
    ST_EL_ROW, ST_EL_F, ST_EL_ISA, ST_EL_ISB, ST_EL_ZERO, ST_NEXT,
    ST_MUL_LD, ST_MUL_RUN, ST_MUL_FIN, ST_SUB_WR,
    ST_BK_IS1, ST_BK_IS2, ST_BK_IS3,
    ST_OUT_ISS, ST_OUT_LD, ST_OUT_V
  } state_e;

  function automatic logic [63:0] magn(input word_t a);
    return a[63] ? (~a + 64'd1) : a;
  endfunction

  function automatic word_t pack(input logic neg, input logic ovf, input logic [63:0] q);
    if (!neg) return (ovf || q[63]) ? WORD_MAX : word_t'(q);
    return (ovf || q[63]) ? WORD_MIN : word_t'(~q + 64'd1);
  endfunction

  function automatic word_t fsub(input word_t a, input word_t b);
    logic signed [64:0] diff;
    diff = {a[63], a} - {b[63], b};
    if (diff[64] != diff[63]) return diff[64] ? WORD_MIN : WORD_MAX;
    return diff[63:0];
  endfunction

  function automatic word_t to_fixed(input logic signed [2*COORD_BITS:0] v);
    word_t v64;
    word_t lim;
    v64 = 64'(v);
    lim = 64'sd1 <<< (63 - FRAC_BITS);
    if (v64 >= lim) return WORD_MAX;
    if (v64 < -lim) return WORD_MIN;
    return v64 <<< FRAC_BITS;
  endfunction

  function automatic logic [ADDR_W-1:0] mat_addr(input logic [3:0] row, input logic [3:0] col);
    logic [7:0] t;
    t = 8'(row[2:0]) * 8'(NCOLS) + 8'(col);
    return t[ADDR_W-1:0];
  endfunction

  // entry of the dlt system for one row and column
  function automatic word_t build_entry(input logic [2:0] row, input logic [3:0] col,
                                        input coord_t sx, input coord_t sy,
                                        input coord_t dx, input coord_t dy);
    coord_t d;
    logic [3:0] base;
    logic signed [2*COORD_BITS-1:0] p;
    logic signed [2*COORD_BITS:0] v;
    d    = row[0] ? dy : dx;
    base = row[0] ? 4'd3 : 4'd0;
    v    = '0;
    if (col == 4'd6) begin
      p = sx * d;
      v = (2*COORD_BITS+1)'(p);
    end else if (col == 4'd7) begin
      p = sy * d;
      v = (2*COORD_BITS+1)'(p);
    end else if (col == 4'd8) begin
      v = -((2*COORD_BITS+1)'(d));
    end else if (col == base) begin
      v = -((2*COORD_BITS+1)'(sx));
    end else if (col == base + 4'd1) begin
      v = -((2*COORD_BITS+1)'(sy));
    end else if (col == base + 4'd2) begin
      v = -(2*COORD_BITS+1)'(1);
    end
    return to_fixed(v);
  endfunction

endpackage

/* rtl/homography_from_four_points.sv */
// items one to three of a set are stored as they arrive; the fourth starts the solve,
//   which runs up to 72 radix-2 divisions of 128 steps each on the shared divider
//   before the first coefficient goes out
// throughput: one homography per four input transactions, one item at a time
// reset: rst_ni asynchronous active low clears the sequencer and the point slot;
//   matrix memory and point store are not cleared and are rebuilt before use
module homography_from_four_points (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // src_x, src_y, dst_x, dst_y (COORD_BITS each, signed), zero pad
  input  logic [hom4_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // coeff_index (4), coeff_value (64, signed Q32.32), zero pad
  output logic [hom4_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // last_coeff
  output logic                              m_axis_tlast
);
  import hom4_pkg::*;

  // sequencer state and loop counters
  state_e      state_q, state_d;
  logic [1:0]  slot_q, slot_d;      // slot for the next correspondence
  logic [3:0]  i_q, i_d;            // row counter
  logic [3:0]  j_q, j_d;            // column counter
  logic [3:0]  h_q, h_d;            // pivot row
  logic [3:0]  k_q, k_d;            // pivot column
  logic [2:0]  best_q, best_d;      // row of largest pivot candidate
  logic        back_q, back_d;      // back substitution phase

  // datapath registers
  logic [63:0] bmag_q, bmag_d;
  word_t       piv_q, piv_d, f_q, f_d, a_q, a_d, b_q, b_d, res_q, res_d, oval_q, oval_d;

  // shared multiply / divide unit
  logic [63:0]  ma_q, ma_d, mb_q, mb_d, dd_q, dd_d, rem_q, rem_d;
  logic [127:0] acc_q, acc_d, num_q, num_d, quo_q, quo_d;
  logic         neg_q, neg_d;
  logic [6:0]   ucnt_q, ucnt_d;

  // point store, no reset: all four slots are written before the build
  coord_t sx_q [4];
  coord_t sy_q [4];
  coord_t dx_q [4];
  coord_t dy_q [4];

  // augmented matrix memory, row-major, one write and one registered read port
  logic [63:0]       mat_mem [MAT_DEPTH];
  logic [63:0]       rdata_q;
  logic [ADDR_W-1:0] raddr, waddr;
  logic              we;
  logic [63:0]       wdata;

  logic in_acc;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i) begin
    if (we) mat_mem[waddr] <= wdata;
    rdata_q <= mat_mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sx_q[slot_q] <= s_axis_tdata[0*COORD_BITS +: COORD_BITS];
      sy_q[slot_q] <= s_axis_tdata[1*COORD_BITS +: COORD_BITS];
      dx_q[slot_q] <= s_axis_tdata[2*COORD_BITS +: COORD_BITS];
      dy_q[slot_q] <= s_axis_tdata[3*COORD_BITS +: COORD_BITS];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      slot_q  <= '0;
      i_q     <= '0;
      j_q     <= '0;
      h_q     <= '0;
      k_q     <= '0;
      best_q  <= '0;
      back_q  <= 1'b0;
      ucnt_q  <= '0;
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
      i_q     <= i_d;
      j_q     <= j_d;
      h_q     <= h_d;
      k_q     <= k_d;
      best_q  <= best_d;
      back_q  <= back_d;
      ucnt_q  <= ucnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bmag_q <= bmag_d;
    piv_q  <= piv_d;
    f_q    <= f_d;
    a_q    <= a_d;
    b_q    <= b_d;
    res_q  <= res_d;
    oval_q <= oval_d;
    ma_q   <= ma_d;
    mb_q   <= mb_d;
    dd_q   <= dd_d;
    rem_q  <= rem_d;
    acc_q  <= acc_d;
    num_q  <= num_d;
    quo_q  <= quo_d;
    neg_q  <= neg_d;
  end

  always_comb begin
    logic [63:0]  mag;
    logic [31:0]  pa, pb;
    logic [63:0]  pp;
    logic [6:0]   shamt;
    logic [127:0] rnd, qsh, q1;
    logic [64:0]  r2;
    logic         ge;
    state_d = state_q;
    slot_d  = slot_q;
    i_d     = i_q;
    j_d     = j_q;
    h_d     = h_q;
    k_d     = k_q;
    best_d  = best_q;
    back_d  = back_q;
    bmag_d  = bmag_q;
    piv_d   = piv_q;
    f_d     = f_q;
    a_d     = a_q;
    b_d     = b_q;
    res_d   = res_q;
    oval_d  = oval_q;
    ma_d    = ma_q;
    mb_d    = mb_q;
    dd_d    = dd_q;
    rem_d   = rem_q;
    acc_d   = acc_q;
    num_d   = num_q;
    quo_d   = quo_q;
    neg_d   = neg_q;
    ucnt_d  = ucnt_q;
    raddr   = '0;
    waddr   = mat_addr(i_q, j_q);
    we      = 1'b0;
    wdata   = '0;
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    mag   = magn(rdata_q);
    pa    = ucnt_q[1] ? ma_q[63:32] : ma_q[31:0];
    pb    = ucnt_q[0] ? mb_q[63:32] : mb_q[31:0];
    pp    = pa * pb;
    shamt = {1'b0, ucnt_q[1], 5'b0} + {1'b0, ucnt_q[0], 5'b0};
    rnd   = acc_q + (128'd1 << (FRAC_BITS - 1));
    qsh   = rnd >> FRAC_BITS;
    r2    = {rem_q, num_q[127]};
    ge    = r2 >= {1'b0, dd_q};
    q1    = quo_q + 128'({rem_q, 1'b0} >= {1'b0, dd_q});

    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          slot_d = slot_q + 2'd1;
          if (slot_q == 2'd3) begin
            i_d = '0;
            j_d = '0;
            h_d = '0;
            k_d = '0;
            back_d = 1'b0;
            state_d = ST_BUILD;
          end
        end
      end
      // one matrix entry per cycle
      ST_BUILD: begin
        we    = 1'b1;
        wdata = build_entry(i_q[2:0], j_q, sx_q[i_q[2:1]], sy_q[i_q[2:1]],
                            dx_q[i_q[2:1]], dy_q[i_q[2:1]]);
        if (j_q == 4'(NCOLS - 1)) begin
          j_d = '0;
          if (i_q == 4'(NROWS - 1)) state_d = ST_PS_START;
          else i_d = i_q + 4'd1;
        end else begin
          j_d = j_q + 4'd1;
        end
      end
      ST_PS_START: begin
        if (h_q == 4'(NROWS) || k_q == 4'(NCOLS)) begin
          i_d = 4'(NROWS - 2);
          j_d = 4'(NROWS - 1);
          back_d = 1'b1;
          state_d = ST_BK_IS1;
        end else begin
          i_d = h_q;
          state_d = ST_PS_ISS;
        end
      end
      ST_PS_ISS: begin
        raddr = mat_addr(i_q, k_q);
        state_d = ST_PS_CMP;
      end
      ST_PS_CMP: begin
        if (i_q == h_q || mag > bmag_q) begin
          best_d = i_q[2:0];
          bmag_d = mag;
        end
        if (i_q == 4'(NROWS - 1)) state_d = ST_PS_DONE;
        else begin
          i_d = i_q + 4'd1;
          state_d = ST_PS_ISS;
        end
      end
      ST_PS_DONE: begin
        if (bmag_q == '0) begin
          k_d = k_q + 4'd1;
          state_d = ST_PS_START;
        end else if ({1'b0, best_q} != h_q) begin
          j_d = '0;
          state_d = ST_SW_RA;
        end else begin
          state_d = ST_NM_PI;
        end
      end
      ST_SW_RA: begin
        raddr = mat_addr(h_q, j_q);
        state_d = ST_SW_RB;
      end
      ST_SW_RB: begin
        a_d = rdata_q;
        raddr = mat_addr({1'b0, best_q}, j_q);
        state_d = ST_SW_W1;
      end
      ST_SW_W1: begin
        we    = 1'b1;
        waddr = mat_addr(h_q, j_q);
        wdata = rdata_q;
        state_d = ST_SW_W2;
      end
      ST_SW_W2: begin
        we    = 1'b1;
        waddr = mat_addr({1'b0, best_q}, j_q);
        wdata = a_q;
        if (j_q == 4'(NCOLS - 1)) state_d = ST_NM_PI;
        else begin
          j_d = j_q + 4'd1;
          state_d = ST_SW_RA;
        end
      end
      ST_NM_PI: begin
        raddr = mat_addr(h_q, k_q);
        state_d = ST_NM_PW;
      end
      ST_NM_PW: begin
        piv_d = rdata_q;
        j_d = '0;
        state_d = ST_NM_ISS;
      end
      ST_NM_ISS: begin
        raddr = mat_addr(h_q, j_q);
        state_d = ST_NM_LD;
      end
      ST_NM_LD: begin
        dd_d   = magn(piv_q);
        neg_d  = rdata_q[63] ^ piv_q[63];
        num_d  = {64'd0, mag} << FRAC_BITS;
        rem_d  = '0;
        quo_d  = '0;
        ucnt_d = '0;
        state_d = ST_DIV_RUN;
      end
      // restoring division, one quotient bit per cycle
      ST_DIV_RUN: begin
        rem_d  = ge ? 64'(r2 - {1'b0, dd_q}) : r2[63:0];
        quo_d  = {quo_q[126:0], ge};
        num_d  = num_q << 1;
        ucnt_d = ucnt_q + 7'd1;
        if (ucnt_q == 7'd127) state_d = ST_DIV_FIN;
      end
      ST_DIV_FIN: begin
        res_d = (dd_q == '0) ? '0 : pack(neg_q, |q1[127:64], q1[63:0]);
        state_d = ST_NM_WR;
      end
      ST_NM_WR: begin
        we    = 1'b1;
        waddr = mat_addr(h_q, j_q);
        wdata = res_q;
        if (j_q == 4'(NCOLS - 1)) begin
          i_d = h_q + 4'd1;
          state_d = ST_EL_ROW;
        end else begin
          j_d = j_q + 4'd1;
          state_d = ST_NM_ISS;
        end
      end
      ST_EL_ROW: begin
        raddr = mat_addr(i_q, k_q);
        if (i_q == 4'(NROWS)) state_d = ST_NEXT;
        else state_d = ST_EL_F;
      end
      ST_EL_F: begin
        f_d = rdata_q;
        if (k_q == 4'(NCOLS - 1)) state_d = ST_EL_ZERO;
        else begin
          j_d = k_q + 4'd1;
          state_d = ST_EL_ISA;
        end
      end
      ST_EL_ISA: begin
        raddr = mat_addr(h_q, j_q);
        state_d = ST_EL_ISB;
      end
      ST_EL_ISB: begin
        a_d = rdata_q;
        raddr = mat_addr(i_q, j_q);
        state_d = ST_MUL_LD;
      end
      ST_EL_ZERO: begin
        we    = 1'b1;
        waddr = mat_addr(i_q, k_q);
        wdata = '0;
        i_d = i_q + 4'd1;
        state_d = ST_EL_ROW;
      end
      ST_NEXT: begin
        h_d = h_q + 4'd1;
        k_d = k_q + 4'd1;
        state_d = ST_PS_START;
      end
      // minuend arrives, product a_q * f_q starts
      ST_MUL_LD: begin
        b_d    = rdata_q;
        ma_d   = magn(a_q);
        mb_d   = magn(f_q);
        neg_d  = a_q[63] ^ f_q[63];
        acc_d  = '0;
        ucnt_d = '0;
        state_d = ST_MUL_RUN;
      end
      // four 32x32 partial products
      ST_MUL_RUN: begin
        acc_d  = acc_q + ({64'd0, pp} << shamt);
        ucnt_d = ucnt_q + 7'd1;
        if (ucnt_q[1:0] == 2'd3) state_d = ST_MUL_FIN;
      end
      ST_MUL_FIN: begin
        res_d = pack(neg_q, |qsh[127:64], qsh[63:0]);
        state_d = ST_SUB_WR;
      end
      ST_SUB_WR: begin
        we    = 1'b1;
        wdata = fsub(b_q, res_q);
        if (back_q) begin
          waddr = mat_addr(i_q, 4'(NCOLS - 1));
          if (j_q == 4'(NROWS - 1)) begin
            if (i_q == '0) state_d = ST_OUT_ISS;
            else begin
              j_d = i_q;
              i_d = i_q - 4'd1;
              state_d = ST_BK_IS1;
            end
          end else begin
            j_d = j_q + 4'd1;
            state_d = ST_BK_IS1;
          end
        end else begin
          waddr = mat_addr(i_q, j_q);
          if (j_q == 4'(NCOLS - 1)) state_d = ST_EL_ZERO;
          else begin
            j_d = j_q + 4'd1;
            state_d = ST_EL_ISA;
          end
        end
      end
      ST_BK_IS1: begin
        raddr = mat_addr(i_q, j_q);
        state_d = ST_BK_IS2;
      end
      ST_BK_IS2: begin
        a_d = rdata_q;
        raddr = mat_addr(j_q, 4'(NCOLS - 1));
        state_d = ST_BK_IS3;
      end
      ST_BK_IS3: begin
        f_d = rdata_q;
        raddr = mat_addr(i_q, 4'(NCOLS - 1));
        state_d = ST_MUL_LD;
      end
      ST_OUT_ISS: begin
        raddr = mat_addr(i_q, 4'(NCOLS - 1));
        state_d = ST_OUT_LD;
      end
      ST_OUT_LD: begin
        oval_d = (i_q == 4'(NROWS)) ? FIX_ONE : word_t'(rdata_q);
        state_d = ST_OUT_V;
      end
      ST_OUT_V: begin
        m_axis_tvalid = 1'b1;
        if (m_axis_tready) begin
          if (i_q == 4'(NROWS)) begin
            back_d = 1'b0;
            state_d = ST_IDLE;
          end else begin
            i_d = i_q + 4'd1;
            state_d = ST_OUT_ISS;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, oval_q, i_q};
  assign m_axis_tlast = (i_q == 4'(NROWS));

endmodule

/* rtl/hom4_checker.sv */
module hom4_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [hom4_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input logic                              m_axis_tlast
);
  import hom4_pkg::*;

  // a stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // no input transaction while coefficients are being delivered
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input ready during output");

  // tlast marks exactly the bottom-right coefficient
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[IDX_W-1:0] == 4'd8)))
    else $error("tlast does not match index");

  // bottom-right coefficient is one
  a_last_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[IDX_W +: 64] == FIX_ONE)
    else $error("last coefficient is not one");

  // coefficient index stays within the nine entries
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[IDX_W-1:0] <= 4'd8)
    else $error("coefficient index out of range");

endmodule

bind homography_from_four_points hom4_checker u_hom4_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
